// File: rtl/nhm_pkg.sv
// Shared constants and types for the NV12 horizontal mirror.
package nhm_pkg;

    // Default line store bank size in bytes.
    localparam int MAX_WIDTH_DEF = 4096;

    // Register map: register index, value after reset.
    localparam int            REG_HALF_WIDTH = 0;
    localparam int            HALF_WIDTH_W   = 12;
    localparam logic [11:0]   HALF_WIDTH_RST = 12'd320;

    // APB geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Request kinds on the input stream.
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Width compare domain: covers 2*half_width and the largest bank.
    localparam int CMP_W = 14;

    // One mirrored byte on its way to the output.
    typedef struct packed {
        logic [7:0] pixel;
        logic       chroma;
        logic       row_end;
    } t_out;

endpackage

// File: rtl/nv12_horizontal_mirror.sv
// Top level: NV12/NV21 row mirror with a two-bank line store.
//
// Input stream (s_*): one request per byte in raster order. tuser[0] is the
// kind (0 push a byte, 1 flush), tuser[1] marks the row as chroma and is
// latched on the row's first byte, tdata is the byte. Pushes fill one bank;
// when half_width*2 bytes are in, that row becomes pending and the banks swap.
// Output stream (m_*): the pending row mirrored, one byte per input request,
// tuser = row type, tlast on the last byte of the row. Luma rows reverse per
// byte, chroma rows reverse per U/V pair. Flush requests drain the last row.
// Throughput is one request per clock while s_tready is high: the store takes
// one write and one read per cycle on separate banks. An accepted request loads
// the store read register, and its byte then moves on to the output register,
// which drives m_*.
// When the receiver stalls, both registers fill; s_tready is low only while
// both hold a byte and m_tready is low, and follows m_tready from then on.
// Reset (i_rst_n low, synchronous) clears counters, pending state and the
// pipeline and sets half_width to 320; the store contents are not cleared.
// APB: half_width at byte address 0; the user must write it only while the block is idle (not enforced).
module nv12_horizontal_mirror
    import nhm_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] pixel
    input  logic [1:0]         s_tuser,   // [0] action, [1] chroma
    // output stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] pixel_out
    output logic               m_tuser,   // [0] chroma_out
    output logic               m_tlast,   // row_end
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int BANK  = MAX_WIDTH - (MAX_WIDTH % 2);
    localparam int DEPTH = 2 * BANK;
    localparam int POS_W = $clog2(BANK + 1);
    localparam int AW    = $clog2(DEPTH);

    // ---------------- configuration ----------------
    logic [HALF_WIDTH_W-1:0] r_half_width;
    logic                    w_reg_sel;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2] == 1'(REG_HALF_WIDTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= HALF_WIDTH_RST;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_half_width <= pwdata[HALF_WIDTH_W-1:0];
        end
    end

    assign prdata = w_reg_sel ? PDATA_W'(r_half_width) : '0;

    // ---------------- row width: 2*half_width clamped to 2..BANK ----------------
    logic [CMP_W-1:0] w_width_raw;
    logic [POS_W-1:0] w_width;

    assign w_width_raw = {(CMP_W - HALF_WIDTH_W)'(0), r_half_width} << 1;

    always_comb begin
        if (r_half_width == '0) begin
            w_width = POS_W'(2);
        end else if (w_width_raw > CMP_W'(BANK)) begin
            w_width = POS_W'(BANK);
        end else begin
            w_width = w_width_raw[POS_W-1:0];
        end
    end

    // ---------------- control state ----------------
    logic [POS_W-1:0] r_wr_pos, n_wr_pos;
    logic [POS_W-1:0] r_rd_pos, n_rd_pos;
    logic             r_wr_bank, n_wr_bank;
    logic             r_pend_valid, n_pend_valid;
    logic             r_pend_chroma, n_pend_chroma;
    logic             r_cur_chroma, n_cur_chroma;

    // pipeline: store read register (a) and output register (b)
    logic r_a_valid, r_b_valid;
    t_out r_a, r_b;

    logic w_accept;
    logic w_push;
    logic w_emit;
    logic w_row_done;
    logic w_chroma_eff;
    logic w_a_move;

    // stall only when both stages hold a byte and the receiver is not taking one
    assign s_tready = !(r_a_valid && r_b_valid && !m_tready);
    assign w_accept = s_tvalid && s_tready;
    assign w_push   = (s_tuser[0] == ACT_PUSH);
    assign w_emit   = r_pend_valid && (r_rd_pos < w_width);

    // mirrored source position inside the pending bank
    logic [POS_W-1:0] w_src;
    logic [POS_W-1:0] w_rd_pos_inc;
    logic [POS_W-1:0] w_wr_pos_inc;

    assign w_rd_pos_inc = r_rd_pos + POS_W'(1);
    assign w_wr_pos_inc = r_wr_pos + POS_W'(1);

    always_comb begin
        if (r_pend_chroma) begin
            w_src = w_width - POS_W'(2) - {r_rd_pos[POS_W-1:1], 1'b0}
                    + POS_W'(r_rd_pos[0]);
        end else begin
            w_src = w_width - POS_W'(1) - r_rd_pos;
        end
    end

    // store addresses: bank 1 sits BANK bytes above bank 0
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;

    assign w_rd_addr = (!r_wr_bank) ? AW'(BANK) + AW'(w_src) : AW'(w_src);
    assign w_wr_addr = r_wr_bank ? AW'(BANK) + AW'(r_wr_pos) : AW'(r_wr_pos);

    assign w_chroma_eff = (r_wr_pos == '0) ? s_tuser[1] : r_cur_chroma;
    assign w_row_done   = w_push && (w_wr_pos_inc >= w_width);

    // next-state logic for one accepted request
    always_comb begin
        n_wr_pos      = r_wr_pos;
        n_rd_pos      = r_rd_pos;
        n_wr_bank     = r_wr_bank;
        n_pend_valid  = r_pend_valid;
        n_pend_chroma = r_pend_chroma;
        n_cur_chroma  = r_cur_chroma;
        if (w_accept) begin
            // read side: emit one byte or retire a row cut short by a width change
            if (w_emit) begin
                n_rd_pos = w_rd_pos_inc;
                if (w_rd_pos_inc >= w_width) begin
                    n_pend_valid = 1'b0;
                end
            end else begin
                n_pend_valid = 1'b0;
            end
            // write side
            if (w_push) begin
                n_cur_chroma = w_chroma_eff;
                if (w_row_done) begin
                    n_pend_valid  = 1'b1;
                    n_pend_chroma = w_chroma_eff;
                    n_rd_pos      = '0;
                    n_wr_bank     = !r_wr_bank;
                    n_wr_pos      = '0;
                end else begin
                    n_wr_pos = w_wr_pos_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos      <= '0;
            r_rd_pos      <= '0;
            r_wr_bank     <= 1'b0;
            r_pend_valid  <= 1'b0;
            r_pend_chroma <= 1'b0;
            r_cur_chroma  <= 1'b0;
        end else begin
            r_wr_pos      <= n_wr_pos;
            r_rd_pos      <= n_rd_pos;
            r_wr_bank     <= n_wr_bank;
            r_pend_valid  <= n_pend_valid;
            r_pend_chroma <= n_pend_chroma;
            r_cur_chroma  <= n_cur_chroma;
        end
    end

    // ---------------- line store: one write port, one registered read port ----
    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (w_accept && w_push) begin
            r_mem[w_wr_addr] <= s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_a.pixel   <= r_mem[w_rd_addr];
            r_a.chroma  <= r_pend_chroma;
            r_a.row_end <= (w_rd_pos_inc >= w_width);
        end
    end

    // ---------------- output pipeline ----------------
    assign w_a_move = r_a_valid && (!r_b_valid || m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_accept && w_emit) begin
                r_a_valid <= 1'b1;
            end else if (w_a_move) begin
                r_a_valid <= 1'b0;
            end
            if (!r_b_valid || m_tready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_move) begin
            r_b <= r_a;
        end
    end

    assign m_tvalid = r_b_valid;
    assign m_tdata  = r_b.pixel;
    assign m_tuser  = r_b.chroma;
    assign m_tlast  = r_b.row_end;

    // ---------------- assertions ----------------
    a_wr_pos_in_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pos < POS_W'(BANK))
        else $error("write position left the bank");

    a_rd_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pos <= POS_W'(BANK))
        else $error("read position beyond bank");

    a_row_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_row_done |=> r_pend_valid && (r_rd_pos == '0))
        else $error("completed row not made pending");

    a_emit_fills_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_emit |=> r_a_valid)
        else $error("emitted byte lost before output stage");

    a_bank_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_row_done |=> r_wr_bank != $past(r_wr_bank))
        else $error("banks did not swap at row end");

endmodule
